>>> rtl/core/assert_macros.svh
// assertion macros used by the checker file srb_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define SRB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define SRB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/srb_pkg.sv
// types and constants of the sequence reorder buffer
package srb_pkg;

  localparam int SEQ_W  = 32;
  localparam int TAG_W  = 16;
  localparam int IDX_W  = 6;

  typedef logic [SEQ_W-1:0] seq_t;
  typedef logic [TAG_W-1:0] tag_t;
  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic set;
    logic clr;
    idx_t idx;
  } slot_ctl_t;

  typedef struct packed {
    logic hit;
    idx_t hit_idx;
    logic free;
    idx_t free_idx;
  } slot_sts_t;

endpackage

>>> rtl/core/srb_ram.sv
// generic single-port-write ram with registered read
module srb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/srb_slots.sv
// slot store: valid bits, sequence numbers and the shared match unit
module srb_slots #(
  parameter int SLOTS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  srb_pkg::seq_t     key,
  input  srb_pkg::slot_ctl_t ctl,
  output srb_pkg::slot_sts_t sts
);

  import srb_pkg::*;

  logic [SLOTS-1:0] valid_r;
  logic [SLOTS-1:0] valid_nxt;
  seq_t             seq_r [SLOTS];
  logic [SLOTS-1:0] match;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      match[i] = valid_r[i] && (seq_r[i] == key);
    end
  end

  // lowest-numbered hit and lowest-numbered free slot
  always_comb begin
    sts = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (match[i]) begin
        sts.hit     = 1'b1;
        sts.hit_idx = IDX_W'(i);
      end
      if (!valid_r[i]) begin
        sts.free     = 1'b1;
        sts.free_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    for (int i = 0; i < SLOTS; i++) begin
      if (ctl.set && ctl.idx == IDX_W'(i)) begin
        valid_nxt[i] = 1'b1;
      end
      if (ctl.clr && ctl.idx == IDX_W'(i)) begin
        valid_nxt[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < SLOTS; i++) begin
      if (ctl.set && ctl.idx == IDX_W'(i)) begin
        seq_r[i] <= key;
      end
    end
  end

endmodule

>>> rtl/core/sequence_reorder_buffer_core.sv
// sequence reorder buffer: holds out-of-order segments and releases them in sequence order
// An item is taken when idle; the block then stalls its input while it works. The check state
// compares the segment against every held slot through the single match unit (stale, duplicate,
// in order, stored in the lowest free slot, or dropped when no slot is free); a dropped segment
// gives one item marked dropped and last once the output register can take it, and after a
// dropped segment or one stored while output is disabled the block returns to idle. With output
// enabled the same match unit then looks up the expected sequence number once per cycle while
// the output does not stall: each hit releases one held segment, and a final miss ends the run
// and returns the block to idle. Tags of held segments come from a small ram. The last released
// item carries last. Results wait in an output register, so the next item can be taken while
// the final one is still unread. Writes to output_enable take effect from the next item on.
module sequence_reorder_buffer_core #(
  parameter int SLOTS     = 16,
  parameter int TAG_WIDTH = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_output_enable,
  input  logic          in_valid,
  output logic          in_stall,
  input  srb_pkg::seq_t in_seq_num,
  input  srb_pkg::tag_t in_payload_tag,
  output logic          out_valid,
  input  logic          out_stall,
  output srb_pkg::seq_t out_seq,
  output srb_pkg::tag_t out_tag,
  output logic          out_dropped,
  output logic          out_last
);

  import srb_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int TW = (TAG_WIDTH < TAG_W) ? TAG_WIDTH : TAG_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_CHECK  = 2'd1;
  localparam logic [1:0] ST_SEARCH = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic          oe_r, oe_nxt;
  seq_t          exp_r, exp_nxt;
  seq_t          seq_r, seq_nxt;
  logic [TW-1:0] tag_r, tag_nxt;
  logic          pend_valid_r, pend_valid_nxt;
  logic          pend_ram_r, pend_ram_nxt;
  seq_t          pend_seq_r, pend_seq_nxt;
  logic [TW-1:0] pend_tag_r, pend_tag_nxt;
  logic          out_valid_r, out_valid_nxt;
  seq_t          out_seq_r, out_seq_nxt;
  tag_t          out_tag_r, out_tag_nxt;
  logic          out_dropped_r, out_dropped_nxt;
  logic          out_last_r, out_last_nxt;

  seq_t          key;
  seq_t          seq_gap;
  slot_ctl_t     ctl;
  slot_sts_t     sts;
  logic          ram_we, ram_re;
  logic [TW-1:0] ram_rdata;
  logic [TW-1:0] pend_tag_eff;
  logic          can_emit;
  logic          direct;

  srb_slots #(.SLOTS(SLOTS)) u_slots (
    .clk   (clk),
    .rst_n (rst_n),
    .key   (key),
    .ctl   (ctl),
    .sts   (sts)
  );

  srb_ram #(.WIDTH(TW), .DEPTH(SLOTS)) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (sts.free_idx[IW-1:0]),
    .wdata (tag_r),
    .re    (ram_re),
    .raddr (sts.hit_idx[IW-1:0]),
    .rdata (ram_rdata)
  );

  assign key          = (state_r == ST_SEARCH) ? exp_r : seq_r;
  assign seq_gap      = seq_r - exp_r;
  assign direct       = oe_r && (seq_r == exp_r);
  assign can_emit     = !out_valid_r || !out_stall;
  assign pend_tag_eff = pend_ram_r ? ram_rdata : pend_tag_r;
  assign in_stall     = (state_r != ST_IDLE);
  assign cfg_ready    = (state_r == ST_IDLE);

  always_comb begin
    state_nxt       = state_r;
    oe_nxt          = oe_r;
    exp_nxt         = exp_r;
    seq_nxt         = seq_r;
    tag_nxt         = tag_r;
    pend_valid_nxt  = pend_valid_r;
    pend_ram_nxt    = pend_ram_r;
    pend_seq_nxt    = pend_seq_r;
    pend_tag_nxt    = pend_tag_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_seq_nxt     = out_seq_r;
    out_tag_nxt     = out_tag_r;
    out_dropped_nxt = out_dropped_r;
    out_last_nxt    = out_last_r;
    ctl             = '0;
    ram_we          = 1'b0;
    ram_re          = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (cfg_valid) begin
          oe_nxt = cfg_output_enable;
        end
        if (in_valid) begin
          seq_nxt   = in_seq_num;
          tag_nxt   = in_payload_tag[TW-1:0];
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (seq_gap[SEQ_W-1] || sts.hit || (!direct && !sts.free)) begin
          if (can_emit) begin
            out_valid_nxt   = 1'b1;
            out_seq_nxt     = seq_r;
            out_tag_nxt     = TAG_W'(tag_r);
            out_dropped_nxt = 1'b1;
            out_last_nxt    = 1'b1;
            state_nxt       = ST_IDLE;
          end
        end else if (direct) begin
          pend_valid_nxt = 1'b1;
          pend_ram_nxt   = 1'b0;
          pend_seq_nxt   = seq_r;
          pend_tag_nxt   = tag_r;
          exp_nxt        = exp_r + 32'd1;
          state_nxt      = ST_SEARCH;
        end else begin
          ctl.set   = 1'b1;
          ctl.idx   = sts.free_idx;
          ram_we    = 1'b1;
          state_nxt = oe_r ? ST_SEARCH : ST_IDLE;
        end
      end
      ST_SEARCH: begin
        if (sts.hit) begin
          if (!pend_valid_r || can_emit) begin
            if (pend_valid_r) begin
              out_valid_nxt   = 1'b1;
              out_seq_nxt     = pend_seq_r;
              out_tag_nxt     = TAG_W'(pend_tag_eff);
              out_dropped_nxt = 1'b0;
              out_last_nxt    = 1'b0;
            end
            pend_valid_nxt = 1'b1;
            pend_ram_nxt   = 1'b1;
            pend_seq_nxt   = exp_r;
            ctl.clr        = 1'b1;
            ctl.idx        = sts.hit_idx;
            ram_re         = 1'b1;
            exp_nxt        = exp_r + 32'd1;
          end
        end else if (!pend_valid_r) begin
          state_nxt = ST_IDLE;
        end else if (can_emit) begin
          out_valid_nxt   = 1'b1;
          out_seq_nxt     = pend_seq_r;
          out_tag_nxt     = TAG_W'(pend_tag_eff);
          out_dropped_nxt = 1'b0;
          out_last_nxt    = 1'b1;
          pend_valid_nxt  = 1'b0;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      oe_r         <= 1'b0;
      exp_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      oe_r         <= oe_nxt;
      exp_r        <= exp_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seq_r         <= seq_nxt;
    tag_r         <= tag_nxt;
    pend_ram_r    <= pend_ram_nxt;
    pend_seq_r    <= pend_seq_nxt;
    pend_tag_r    <= pend_tag_nxt;
    out_seq_r     <= out_seq_nxt;
    out_tag_r     <= out_tag_nxt;
    out_dropped_r <= out_dropped_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_seq     = out_seq_r;
  assign out_tag     = out_tag_r;
  assign out_dropped = out_dropped_r;
  assign out_last    = out_last_r;

endmodule

>>> rtl/core/srb_checker.sv
// port-level checks of the sequence reorder buffer and their bind
`include "assert_macros.svh"

module srb_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          cfg_ready,
  input logic          in_valid,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input logic          out_dropped,
  input logic          out_last
);

  `SRB_ASSERT(a_out_held, out_valid && out_stall |=> out_valid, "stalled item withdrawn")
  `SRB_ASSERT(a_drop_last, out_valid && out_dropped |-> out_last, "dropped item not last")
  `SRB_ASSERT(a_busy_after_accept, in_valid && !in_stall |=> in_stall, "no stall after accept")
  `SRB_ASSERT(a_cfg_idle, cfg_ready |-> !in_stall, "config ready while busy")
  `SRB_ASSERT_ALWAYS(a_reset_out, !rst_n |=> !out_valid, "output valid after reset")

endmodule

bind sequence_reorder_buffer_core srb_checker u_srb_checker (.*);
